@@ rtl/tfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfc_pkg
// Types and constants shared by the texel format converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register indexes (byte address bit 2)
    localparam logic REG_TEXEL_FORMAT = 1'b0;
    localparam logic REG_TEXEL_SIZE   = 1'b1;

    // Texel format codes
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_CI   = 3'd2;
    localparam logic [2:0] FMT_IA   = 3'd3;
    localparam logic [2:0] FMT_I    = 3'd4;

    // Texel size codes
    localparam logic [1:0] SIZE_4B  = 2'd0;
    localparam logic [1:0] SIZE_8B  = 2'd1;
    localparam logic [1:0] SIZE_16B = 2'd2;
    localparam logic [1:0] SIZE_32B = 2'd3;

    localparam logic [2:0] FMT_RESET  = FMT_RGBA;
    localparam logic [1:0] SIZE_RESET = SIZE_16B;

    localparam logic [3:0] ALPHA_FULL = 4'hF;
    localparam logic [3:0] ALPHA_NONE = 4'h0;

    typedef struct packed {
        logic [2:0] texel_format;
        logic [1:0] texel_size;
    } t_cfg;

    // Decoded conversion per format and size
    typedef enum logic [3:0] {
        MODE_BAD    = 4'd0,
        MODE_RGBA16 = 4'd1,
        MODE_RGBA32 = 4'd2,
        MODE_IA4    = 4'd3,
        MODE_IA8    = 4'd4,
        MODE_IA16   = 4'd5,
        MODE_I4     = 4'd6,
        MODE_I8     = 4'd7,
        MODE_CI4    = 4'd8,
        MODE_CI8    = 4'd9
    } t_mode;

    typedef struct packed {
        logic        cmd;
        logic [31:0] texel_bits;
        logic [7:0]  palette_index;
        logic [15:0] palette_value;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] pixel;
        logic        pixel_format;
        logic        pixel_valid;
    } t_out_beat;

    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    localparam logic PIXFMT_1555 = 1'b0;
    localparam logic PIXFMT_4444 = 1'b1;

endpackage

`default_nettype wire

@@ rtl/tfc_ram.sv @@
// ----------------------------------------------------------------------------
// tfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/tfc_regs.sv @@
// ----------------------------------------------------------------------------
// tfc_regs
// APB-style configuration registers: texel format and texel size.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_psel,
    input  wire logic                             i_penable,
    input  wire logic                             i_pwrite,
    input  wire logic [tfc_pkg::CFG_ADDR_W-1:0]   i_paddr,
    input  wire logic [tfc_pkg::CFG_DATA_W-1:0]   i_pwdata,
    output logic      [tfc_pkg::CFG_DATA_W-1:0]   o_prdata,
    output logic                                  o_pready,
    output tfc_pkg::t_cfg                         o_cfg
);

    tfc_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic          reg_sel;

    assign o_pready = 1'b1;
    assign reg_sel  = i_paddr[2];
    assign wr_en    = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.texel_format <= tfc_pkg::FMT_RESET;
            r_cfg.texel_size   <= tfc_pkg::SIZE_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                tfc_pkg::REG_TEXEL_FORMAT: r_cfg.texel_format <= i_pwdata[2:0];
                tfc_pkg::REG_TEXEL_SIZE:   r_cfg.texel_size   <= i_pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_sel)
            tfc_pkg::REG_TEXEL_FORMAT: o_prdata[2:0] = r_cfg.texel_format;
            tfc_pkg::REG_TEXEL_SIZE:   o_prdata[1:0] = r_cfg.texel_size;
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/tfc_pipe.sv @@
// ----------------------------------------------------------------------------
// tfc_pipe
// Three-stage conversion pipeline with the palette RAM.
// Stage A: decode and palette read. Stage B: source select and ARGB4444
// build. Stage C: final pixel, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_pipe #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tfc_pkg::t_cfg      i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tfc_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tfc_pkg::t_out_beat      o_out_data
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    function automatic logic [15:0] gray4444(input logic [3:0] a, input logic [3:0] i);
        gray4444 = {a, i, i, i};
    endfunction

    // Handshake chain
    logic ready_a, ready_b, ready_c;
    logic in_accept;

    // Stage A
    logic               r_a_valid;
    tfc_pkg::t_mode     r_a_mode;
    logic [31:0]        r_a_texel;
    logic               r_a_hit;
    tfc_pkg::t_mode     n_a_mode;
    logic [7:0]         pal_idx;
    logic               n_a_hit;
    logic [15:0]        ram_rd_data;
    logic               pal_we;

    // Stage B
    logic               r_b_valid;
    logic [15:0]        r_b_color;
    logic [15:0]        r_b_argb4444;
    logic               r_b_is_4444;
    logic               r_b_ok;
    logic [15:0]        n_b_color;
    logic [15:0]        n_b_argb4444;
    logic               n_b_is_4444;
    logic [7:0]         ia4_int;

    // Stage C
    logic               r_c_valid;
    tfc_pkg::t_out_beat r_c_data;
    tfc_pkg::t_out_beat n_c_data;

    assign ready_c    = !r_c_valid || i_out_ready;
    assign ready_b    = !r_b_valid || ready_c;
    assign ready_a    = !r_a_valid || ready_b;
    assign o_in_ready = ready_a;
    assign in_accept  = i_in_valid && ready_a;

    // ---------------- Stage A ----------------
    always_comb begin
        n_a_mode = tfc_pkg::MODE_BAD;
        unique case (i_cfg.texel_format)
            tfc_pkg::FMT_RGBA: begin
                if (i_cfg.texel_size == tfc_pkg::SIZE_16B) n_a_mode = tfc_pkg::MODE_RGBA16;
                if (i_cfg.texel_size == tfc_pkg::SIZE_32B) n_a_mode = tfc_pkg::MODE_RGBA32;
            end
            tfc_pkg::FMT_CI: begin
                if (i_cfg.texel_size == tfc_pkg::SIZE_4B) n_a_mode = tfc_pkg::MODE_CI4;
                if (i_cfg.texel_size == tfc_pkg::SIZE_8B) n_a_mode = tfc_pkg::MODE_CI8;
            end
            tfc_pkg::FMT_IA: begin
                if (i_cfg.texel_size == tfc_pkg::SIZE_4B)  n_a_mode = tfc_pkg::MODE_IA4;
                if (i_cfg.texel_size == tfc_pkg::SIZE_8B)  n_a_mode = tfc_pkg::MODE_IA8;
                if (i_cfg.texel_size == tfc_pkg::SIZE_16B) n_a_mode = tfc_pkg::MODE_IA16;
            end
            tfc_pkg::FMT_I: begin
                if (i_cfg.texel_size == tfc_pkg::SIZE_4B) n_a_mode = tfc_pkg::MODE_I4;
                if (i_cfg.texel_size == tfc_pkg::SIZE_8B) n_a_mode = tfc_pkg::MODE_I8;
            end
            default: ;
        endcase
    end

    // 4-bit indexes land inside a palette of 16 or more entries; 8-bit ones may not
    assign pal_idx = (n_a_mode == tfc_pkg::MODE_CI4) ? {4'h0, i_in_data.texel_bits[3:0]}
                                                     : i_in_data.texel_bits[7:0];
    assign n_a_hit = {1'b0, pal_idx} < 9'(PALETTE_ENTRIES);

    // Drop writes beyond the palette
    assign pal_we = in_accept && (i_in_data.cmd == tfc_pkg::CMD_PAL_WRITE) &&
                    ({1'b0, i_in_data.palette_index} < 9'(PALETTE_ENTRIES));

    // Read data advances only on an accepted beat, so it stays aligned with stage A
    tfc_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_we      (pal_we),
        .i_wr_addr (i_in_data.palette_index[ADDR_W-1:0]),
        .i_wr_data (i_in_data.palette_value),
        .i_rd_en   (in_accept),
        .i_rd_addr (pal_idx[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= in_accept && (i_in_data.cmd == tfc_pkg::CMD_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_mode  <= n_a_mode;
            r_a_texel <= i_in_data.texel_bits;
            r_a_hit   <= n_a_hit;
        end
    end

    // ---------------- Stage B ----------------
    // (v >> 1) * 0x24, top nibble kept
    assign ia4_int = {r_a_texel[3:1], 5'b0} + {3'b0, r_a_texel[3:1], 2'b0};

    always_comb begin
        n_b_color    = '0;
        n_b_argb4444 = '0;
        n_b_is_4444  = 1'b0;
        case (r_a_mode) inside
            tfc_pkg::MODE_RGBA16: n_b_color = r_a_texel[15:0];
            tfc_pkg::MODE_CI4, tfc_pkg::MODE_CI8: begin
                if (r_a_hit) n_b_color = ram_rd_data;
            end
            tfc_pkg::MODE_RGBA32: begin
                n_b_is_4444  = 1'b1;
                n_b_argb4444 = {(r_a_texel[7:0] != 8'h00) ? tfc_pkg::ALPHA_FULL
                                                          : tfc_pkg::ALPHA_NONE,
                                r_a_texel[31:28], r_a_texel[23:20], r_a_texel[15:12]};
            end
            tfc_pkg::MODE_IA4: begin
                n_b_is_4444  = 1'b1;
                n_b_argb4444 = gray4444(r_a_texel[0] ? tfc_pkg::ALPHA_FULL
                                                     : tfc_pkg::ALPHA_NONE,
                                        ia4_int[7:4]);
            end
            tfc_pkg::MODE_IA8: begin
                n_b_is_4444  = 1'b1;
                n_b_argb4444 = gray4444(r_a_texel[3:0], r_a_texel[7:4]);
            end
            tfc_pkg::MODE_IA16: begin
                n_b_is_4444  = 1'b1;
                n_b_argb4444 = gray4444(r_a_texel[7:4], r_a_texel[15:12]);
            end
            tfc_pkg::MODE_I4: begin
                n_b_is_4444  = 1'b1;
                n_b_argb4444 = gray4444(tfc_pkg::ALPHA_FULL, r_a_texel[3:0]);
            end
            tfc_pkg::MODE_I8: begin
                n_b_is_4444  = 1'b1;
                n_b_argb4444 = gray4444(tfc_pkg::ALPHA_FULL, r_a_texel[7:4]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_valid) begin
            r_b_color    <= n_b_color;
            r_b_argb4444 <= n_b_argb4444;
            r_b_is_4444  <= n_b_is_4444;
            r_b_ok       <= (r_a_mode != tfc_pkg::MODE_BAD);
        end
    end

    // ---------------- Stage C ----------------
    // v*255/31 keeps its top 5 bits equal to v, so RGBA5551 to ARGB1555
    // is a rotate of the alpha bit to the top.
    always_comb begin
        n_c_data.pixel_valid  = r_b_ok;
        n_c_data.pixel_format = tfc_pkg::PIXFMT_1555;
        n_c_data.pixel        = '0;
        if (r_b_ok) begin
            if (r_b_is_4444) begin
                n_c_data.pixel_format = tfc_pkg::PIXFMT_4444;
                n_c_data.pixel        = r_b_argb4444;
            end else begin
                n_c_data.pixel        = {r_b_color[0], r_b_color[15:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_b_valid) begin
            r_c_data <= n_c_data;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_data  = r_c_data;

`ifndef SYNTHESIS
    a_pal_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.cmd == tfc_pkg::CMD_PAL_WRITE) |=> !r_a_valid)
        else $error("palette write produced a stage A item");

    a_convert_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.cmd == tfc_pkg::CMD_CONVERT) |=> r_a_valid)
        else $error("accepted conversion lost at stage A");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !r_c_data.pixel_valid) |->
            (r_c_data.pixel == 16'h0000 && r_c_data.pixel_format == tfc_pkg::PIXFMT_1555))
        else $error("unsupported combination gave a nonzero result");

    a_stage_b_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !ready_c) |=> (r_b_valid && $stable(r_b_argb4444) && $stable(r_b_color)))
        else $error("stage B changed while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/texel_format_converter_unit.sv @@
// ----------------------------------------------------------------------------
// texel_format_converter_unit
// Converts unpacked texels to ARGB1555 or ARGB4444, one per unstalled clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data) takes one beat per cycle
//   unless stalled: cmd selects a texel conversion or a palette entry write.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one
//   pixel per conversion beat; palette writes return nothing.
//   o_out_valid rises once the beat has passed the palette read at stage A,
//   the select at stage B and the output register at stage C. Throughput
//   is one beat per cycle while i_out_ready is high: every stage advances
//   whenever the stage after it can take its beat.
//   Texel format and size are set over the APB port (address 0 and 4) and
//   the user must change them only while the pipeline is empty; unchecked.
//   Reset empties the pipeline and sets format RGBA, size 16-bit. The palette
//   has no reset; read only entries written since reset.
//   When the receiver stalls, each stage holds its beat; o_in_ready drops
//   once all three stages are full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module texel_format_converter_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tfc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [tfc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [tfc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire tfc_pkg::t_in_beat                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output tfc_pkg::t_out_beat                    o_out_data
);

    tfc_pkg::t_cfg cfg;

    tfc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    tfc_pipe #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
